>>> rtl/tpa_pkg.sv
// ----------------------------------------------------------------------------
// tpa_pkg: telecommand packet acceptor shared definitions
// Types, constants, result codes and the byte-wise CRC update.
// ----------------------------------------------------------------------------
`default_nettype none

package tpa_pkg;

    localparam int COUNT_W = 17;

    typedef logic [COUNT_W-1:0] count_t;

    localparam count_t COUNT_MAX        = {COUNT_W{1'b1}};
    localparam count_t MIN_PACKET_BYTES = 17'd13;
    localparam count_t PRI_HDR_BYTES    = 17'd6;
    localparam count_t SEC_HDR_END      = 17'd11;
    localparam count_t CRC_START        = 17'd2;
    localparam count_t LENGTH_OFFSET    = 17'd7;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [3:0] PUS_VERSION_REQUIRED = 4'd2;
    localparam logic [7:0] SERVICE_REQUIRED     = 8'd17;

    // Primary header framing fields
    localparam logic [2:0] CCSDS_VERSION = 3'd0;
    localparam logic       TYPE_TC       = 1'b1;
    localparam logic [1:0] SEQ_UNSEGMENTED = 2'b11;

    // Verdict codes
    localparam logic [2:0] VERDICT_ACCEPTED    = 3'd0;
    localparam logic [2:0] VERDICT_LENGTH_ERR  = 3'd1;
    localparam logic [2:0] VERDICT_CRC_FAIL    = 3'd2;
    localparam logic [2:0] VERDICT_BAD_PUS     = 3'd3;
    localparam logic [2:0] VERDICT_BAD_SERVICE = 3'd4;

    // Packet summary handed from the accumulator to the checker
    typedef struct packed {
        count_t      byte_count;
        logic [47:0] primary_hdr;
        logic [39:0] secondary_hdr;
        logic        crc_ok;
    } pkt_sum_t;

    // CRC-16/CCITT-FALSE, one byte, MSB first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/tpa_byte_if.sv
// ----------------------------------------------------------------------------
// tpa_byte_if: packet byte channel
// Valid/ready channel carrying one packet byte and its last-byte marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpa_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/tpa_result_if.sv
// ----------------------------------------------------------------------------
// tpa_result_if: acceptance report channel
// Valid/ready channel carrying one acceptance verdict word per packet.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpa_result_if;
    logic        valid;
    logic        ready;
    logic        addressed;
    logic [2:0]  verdict;
    logic [3:0]  ack_mask;
    logic [15:0] source_ident;
    logic [7:0]  service_kind;
    logic [7:0]  service_subkind;

    modport source (output valid, output addressed, output verdict, output ack_mask,
                    output source_ident, output service_kind, output service_subkind,
                    input ready);
    modport sink   (input valid, input addressed, input verdict, input ack_mask,
                    input source_ident, input service_kind, input service_subkind,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/tpa_cfg_if.sv
// ----------------------------------------------------------------------------
// tpa_cfg_if: configuration write channel
// Valid/ready channel carrying the expected APID register value.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpa_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] apid;

    modport source (output valid, output apid, input ready);
    modport sink   (input valid, input apid, output ready);
endinterface

`default_nettype wire

>>> rtl/tpa_accum.sv
// ----------------------------------------------------------------------------
// tpa_accum: byte accumulator
// Registers each incoming byte, captures the headers, runs the CRC over all
// bytes but the last two, and hands a packet summary on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tpa_accum
    import tpa_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    tpa_byte_if.sink   pkt,
    input  wire logic  sum_ready,
    output logic       sum_valid,
    output pkt_sum_t   sum
);

    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        advance;

    count_t      count_reg,   count_next;
    logic [47:0] pri_reg,     pri_next;
    logic [39:0] sec_reg,     sec_next;
    logic [15:0] crc_reg,     crc_next;
    logic [15:0] pair_reg,    pair_next;

    // Advance the held word unless a finished packet cannot be handed on
    assign advance   = in_vld_reg && (!in_last_reg || sum_ready);
    assign pkt.ready = !in_vld_reg || advance;
    assign sum_valid = in_vld_reg && in_last_reg;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (pkt.valid && pkt.ready)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt.valid && pkt.ready)
        begin
            in_byte_reg <= pkt.data_byte;
            in_last_reg <= pkt.last_byte;
        end
    end

    // Next packet state with the held byte folded in
    always_comb
    begin
        pri_next = pri_reg;
        sec_next = sec_reg;
        if (count_reg < PRI_HDR_BYTES)
            pri_next = {pri_reg[39:0], in_byte_reg};
        else if (count_reg < SEC_HDR_END)
            sec_next = {sec_reg[31:0], in_byte_reg};

        if (count_reg >= CRC_START)
            crc_next = crc_feed(crc_reg, pair_reg[15:8]);
        else
            crc_next = crc_reg;
        pair_next = {pair_reg[7:0], in_byte_reg};

        if (count_reg != COUNT_MAX)
            count_next = count_reg + 17'd1;
        else
            count_next = count_reg;
    end

    assign sum.byte_count    = count_next;
    assign sum.primary_hdr   = pri_next;
    assign sum.secondary_hdr = sec_next;
    assign sum.crc_ok        = (crc_next == pair_next);

    // Packet state: hold, advance, or clear after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pri_reg   <= '0;
            sec_reg   <= '0;
            crc_reg   <= CRC_INIT;
            pair_reg  <= '0;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                count_reg <= '0;
                pri_reg   <= '0;
                sec_reg   <= '0;
                crc_reg   <= CRC_INIT;
                pair_reg  <= '0;
            end
            else
            begin
                count_reg <= count_next;
                pri_reg   <= pri_next;
                sec_reg   <= sec_next;
                crc_reg   <= crc_next;
                pair_reg  <= pair_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/tpa_judge.sv
// ----------------------------------------------------------------------------
// tpa_judge: acceptance checker
// Holds the expected APID, checks a packet summary and registers the report.
// ----------------------------------------------------------------------------
`default_nettype none

module tpa_judge
    import tpa_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    tpa_cfg_if.sink       cfg,
    input  wire logic     sum_valid,
    input  wire pkt_sum_t sum,
    output logic          sum_ready,
    tpa_result_if.source  report
);

    logic [10:0] apid_reg;
    logic        out_vld_reg;
    logic        load;

    logic        addr_next;
    logic [2:0]  verdict_next;
    logic [3:0]  ack_next;
    logic [15:0] src_next;
    logic [7:0]  svc_next;
    logic [7:0]  sub_next;

    logic        framing_ok;
    logic [16:0] expected_len;

    logic        addr_reg;
    logic [2:0]  verdict_reg;
    logic [3:0]  ack_reg;
    logic [15:0] src_reg;
    logic [7:0]  svc_reg;
    logic [7:0]  sub_reg;

    // Configuration register, always writable
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            apid_reg <= '0;
        else if (cfg.valid)
            apid_reg <= cfg.apid;
    end

    // Checks in order: address, length, CRC, PUS version, service
    always_comb
    begin
        framing_ok = (sum.primary_hdr[47:45] == CCSDS_VERSION) &&
                     (sum.primary_hdr[44] == TYPE_TC) &&
                     sum.primary_hdr[43] &&
                     (sum.primary_hdr[31:30] == SEQ_UNSEGMENTED);
        expected_len = {1'b0, sum.primary_hdr[15:0]} + LENGTH_OFFSET;

        addr_next    = 1'b0;
        verdict_next = VERDICT_ACCEPTED;
        ack_next     = '0;
        src_next     = '0;
        svc_next     = '0;
        sub_next     = '0;

        if ((sum.byte_count >= PRI_HDR_BYTES) && framing_ok &&
            (sum.primary_hdr[42:32] == apid_reg))
        begin
            addr_next = 1'b1;
            if ((sum.byte_count < MIN_PACKET_BYTES) || (sum.byte_count != expected_len))
            begin
                verdict_next = VERDICT_LENGTH_ERR;
            end
            else
            begin
                ack_next = sum.secondary_hdr[35:32];
                svc_next = sum.secondary_hdr[31:24];
                sub_next = sum.secondary_hdr[23:16];
                src_next = sum.secondary_hdr[15:0];
                if (!sum.crc_ok)
                    verdict_next = VERDICT_CRC_FAIL;
                else if (sum.secondary_hdr[39:36] != PUS_VERSION_REQUIRED)
                    verdict_next = VERDICT_BAD_PUS;
                else if (sum.secondary_hdr[31:24] != SERVICE_REQUIRED)
                    verdict_next = VERDICT_BAD_SERVICE;
                else
                    verdict_next = VERDICT_ACCEPTED;
            end
        end
    end

    // Result register: load when empty or being drained
    assign sum_ready = !out_vld_reg || report.ready;
    assign load      = sum_valid && sum_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (load)
            out_vld_reg <= 1'b1;
        else if (report.ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            addr_reg    <= addr_next;
            verdict_reg <= verdict_next;
            ack_reg     <= ack_next;
            src_reg     <= src_next;
            svc_reg     <= svc_next;
            sub_reg     <= sub_next;
        end
    end

    assign report.valid           = out_vld_reg;
    assign report.addressed       = addr_reg;
    assign report.verdict         = verdict_reg;
    assign report.ack_mask        = ack_reg;
    assign report.source_ident    = src_reg;
    assign report.service_kind    = svc_reg;
    assign report.service_subkind = sub_reg;

endmodule

`default_nettype wire

>>> rtl/telecommand_packet_acceptor_unit.sv
// ----------------------------------------------------------------------------
// telecommand_packet_acceptor_unit: telecommand acceptance check
// Channels: pkt takes one packet byte per word with a last-byte marker; report
// gives one verdict word per packet; cfg writes the expected APID (always
// ready, write only while no packet is in flight).
// Throughput: one byte per cycle, except that a last byte waits while the
// report word is stalled; each byte passes an input register, then the header
// capture and one-byte CRC update run combinationally on the held byte.
// Report path: the summary of the held last byte is checked and loaded into
// the result register, which gives the report word.
// Stall: a waiting report word holds in the result register; bytes of the
// next packet keep flowing, and only its last byte waits in the input
// register until the report word is taken.
// Reset: clears the APID register to zero, empties both registers and
// returns the packet state (count, headers, CRC 0xFFFF) to its start values.
// ----------------------------------------------------------------------------
`default_nettype none

module telecommand_packet_acceptor_unit
    import tpa_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    tpa_byte_if.sink     pkt,
    tpa_cfg_if.sink      cfg,
    tpa_result_if.source report
);

    logic     sum_valid;
    logic     sum_ready;
    pkt_sum_t sum;

    // Byte intake and packet state
    tpa_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt       (pkt),
        .sum_ready (sum_ready),
        .sum_valid (sum_valid),
        .sum       (sum)
    );

    // Verdict and report register
    tpa_judge u_judge (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .sum_valid (sum_valid),
        .sum       (sum),
        .sum_ready (sum_ready),
        .report    (report)
    );

endmodule

`default_nettype wire
